// ----- rtl/pva_pkg.sv -----
// Shared types and constants for the priority voice allocator.
package pva_pkg;

  localparam int unsigned CfgW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ChanW   = 6;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned BusyW   = 64;

  localparam logic [CfgIdxW-1:0] CFG_NUM_CHANNELS     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_3D_CHANNEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HAS_3D           = 2'd2;

  localparam logic [1:0] MODE_FIND_2D = 2'd0;
  localparam logic [1:0] MODE_FIND_3D = 2'd1;
  localparam logic [1:0] MODE_PLAY    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PrioW-1:0] priority_req;
    logic [ChanW-1:0] channel;
    logic [BusyW-1:0] busy_mask;
  } pva_in_t;

  typedef struct packed {
    logic [ChanW-1:0] chosen_channel;
    logic             ok;
    logic             stolen;
  } pva_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture a new request
    logic scan;    // request in progress
    logic commit;  // write result register, apply play update
  } pva_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;    // result of the current request is settled
  } pva_sts_t;

endpackage

// ----- rtl/pva_ctrl.sv -----
// Controller: request sequencing and output register handshake.
module pva_ctrl
  import pva_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pva_sts_t sts_i,
  output pva_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } pva_state_e;

  pva_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.load   = 1'b0;
    cmd_o.scan   = 1'b0;
    cmd_o.commit = 1'b0;
    state_d      = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BUSY;
        end
      end
      ST_BUSY: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done && slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/pva_datapath.sv -----
// Datapath: config registers, priority table, channel scan and result register.
module pva_datapath
  import pva_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  pva_in_t            in_data_i,
  output pva_out_t           out_data_o,
  input  pva_cmd_t           cmd_i,
  output pva_sts_t           sts_o
);

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [CfgW-1:0] MaxCnt = CfgW'(MAX_CHANNELS);

  // configuration
  logic [CfgW-1:0] num_channels_q, first_3d_q;
  logic            has_3d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= 7'd64;
      first_3d_q     <= '0;
      has_3d_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_CHANNELS:     num_channels_q <= cfg_data_i;
        CFG_FIRST_3D_CHANNEL: first_3d_q     <= cfg_data_i;
        CFG_HAS_3D:           has_3d_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request registers
  pva_in_t         item_q;
  logic [CfgW-1:0] count_q, addr_q;
  logic            fail_q, play_q;
  logic            pend_q, free_q, have_q;
  logic [PrioW-1:0] best_prio_q;
  logic [ChanW-1:0] best_idx_q;

  // table read stage
  logic [PrioW-1:0] mem_q [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld_q;
  logic [PrioW-1:0] rd_prio_q;
  logic [ChanW-1:0] rd_idx_q;
  logic             rd_busy_q;

  logic            issue, eval, better, play_ok, tbl_we;
  logic [CfgW-1:0] count_ld;
  pva_out_t        res;
  pva_out_t        out_q;

  assign count_ld = (num_channels_q > MaxCnt) ? MaxCnt : num_channels_q;
  assign issue    = cmd_i.scan && !fail_q && !play_q && !free_q && (addr_q < count_q);
  assign eval     = pend_q && !free_q;
  assign better   = (rd_prio_q < item_q.priority_req) && (!have_q || rd_prio_q <= best_prio_q);
  assign play_ok  = {1'b0, item_q.channel} < count_q;
  assign tbl_we   = cmd_i.commit && play_q && play_ok;

  assign sts_o.done = fail_q || play_q || free_q || ((addr_q >= count_q) && !pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      free_q <= 1'b0;
      have_q <= 1'b0;
      fail_q <= 1'b0;
      play_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        pend_q <= 1'b0;
        free_q <= 1'b0;
        have_q <= 1'b0;
        fail_q <= (in_data_i.mode == MODE_UNUSED) ||
                  ((in_data_i.mode == MODE_FIND_3D) && !has_3d_q);
        play_q <= (in_data_i.mode == MODE_PLAY);
      end else begin
        pend_q <= issue;
        if (eval) begin
          if (!rd_busy_q) free_q <= 1'b1;
          else if (better) have_q <= 1'b1;
        end
      end
      if (tbl_we) vld_q[item_q.channel[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= in_data_i;
      count_q <= count_ld;
      addr_q  <= (in_data_i.mode == MODE_FIND_3D) ? first_3d_q : '0;
    end else if (issue) begin
      addr_q <= addr_q + 1'b1;
    end
    if (issue) begin
      rd_prio_q <= vld_q[addr_q[AW-1:0]] ? mem_q[addr_q[AW-1:0]] : '0;
      rd_idx_q  <= addr_q[ChanW-1:0];
      rd_busy_q <= item_q.busy_mask[addr_q[ChanW-1:0]];
    end
    if (eval && (!rd_busy_q || better)) begin
      best_idx_q  <= rd_idx_q;
      best_prio_q <= rd_prio_q;
    end
    if (tbl_we) mem_q[item_q.channel[AW-1:0]] <= item_q.priority_req;
    if (cmd_i.commit) out_q <= res;
  end

  always_comb begin
    res = '0;
    if (play_q) begin
      if (play_ok) begin
        res.chosen_channel = item_q.channel;
        res.ok             = 1'b1;
      end
    end else if (!fail_q) begin
      if (free_q) begin
        res.chosen_channel = best_idx_q;
        res.ok             = 1'b1;
      end else if (have_q) begin
        res.chosen_channel = best_idx_q;
        res.ok             = 1'b1;
        res.stolen         = 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_free_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && free_q && !play_q && !fail_q |-> !item_q.busy_mask[best_idx_q])
    else $error("free channel result points at a busy channel");
  a_steal_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q && !free_q |-> best_prio_q < item_q.priority_req)
    else $error("steal candidate not below requested priority");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> {1'b0, rd_idx_q} < count_q)
    else $error("table read outside channel range");
`endif

endmodule

// ----- rtl/priority_voice_allocator.sv -----
// Top level: priority voice allocator with busy search and priority stealing.
//
// One request is handled at a time. A find request scans its channel range one
// table entry per cycle through the priority table's single registered read
// port. It stops at the first idle channel, or scans the whole range when every
// channel in it is busy. Play requests, unused modes, 3D requests with no 3D
// mixer and finds over an empty range finish without a table scan. The result
// sits in an output register, so a new request is taken while the last result
// waits. A held result stalls the next request's result for as long as
// out_ready_i stays low.
// The table starts all zero after reset with no clearing pass.
module priority_voice_allocator
  import pva_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pva_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pva_out_t           out_data_o
);

  pva_cmd_t cmd;
  pva_sts_t sts;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pva_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ----- sim/priority_voice_allocator_tb.sv -----
// Testbench for the priority voice allocator: random traffic checked against a built-in predictor.
`timescale 1ns / 100ps

module priority_voice_allocator_tb;
  import pva_pkg::*;

  localparam int unsigned MAX_CH         = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  pva_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  pva_out_t           out_data_o;

  // predictor state: configuration and stored channel priorities
  logic [CfgW-1:0]  cfg_num_ch   = 7'd64;
  logic [CfgW-1:0]  cfg_first_3d = 7'd0;
  logic             cfg_has_3d   = 1'b1;
  logic [PrioW-1:0] prio_table [MAX_CH];

  pva_in_t     request_q[$];
  pva_out_t    alloc_expect_q[$];
  int unsigned issued      = 0;
  int unsigned accepted    = 0;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  logic        no_gaps     = 1'b0;

  priority_voice_allocator #(
    .MAX_CHANNELS(MAX_CH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    foreach (prio_table[k]) prio_table[k] = '0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Free channel first, else steal the lowest stored priority under the request
  // (ties go to the highest index).
  function automatic pva_out_t predict_alloc(pva_in_t req);
    pva_out_t         res;
    int unsigned      count;
    int unsigned      first;
    int unsigned      low_idx;
    logic             found;
    logic             have;
    logic [PrioW-1:0] low_prio;
    res      = '0;
    count    = (cfg_num_ch > MAX_CH) ? MAX_CH : cfg_num_ch;
    first    = 0;
    low_idx  = 0;
    found    = 1'b0;
    have     = 1'b0;
    low_prio = '0;
    if (req.mode == MODE_PLAY) begin
      if (req.channel < count) begin
        prio_table[req.channel] = req.priority_req;
        res.chosen_channel = req.channel;
        res.ok = 1'b1;
      end
    end else if (req.mode == MODE_FIND_2D || (req.mode == MODE_FIND_3D && cfg_has_3d)) begin
      if (req.mode == MODE_FIND_3D) first = cfg_first_3d;
      for (int unsigned i = first; i < count && !found; i++) begin
        if (!req.busy_mask[i]) begin
          found = 1'b1;
          res.chosen_channel = 6'(i);
          res.ok = 1'b1;
        end
      end
      if (!found) begin
        for (int unsigned i = first; i < count; i++) begin
          if (prio_table[i] < req.priority_req && (!have || prio_table[i] <= low_prio)) begin
            have     = 1'b1;
            low_prio = prio_table[i];
            low_idx  = i;
          end
        end
        if (have) begin
          res.chosen_channel = 6'(low_idx);
          res.ok = 1'b1;
          res.stolen = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap != 0) begin
        send_gap   = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_data_i  <= request_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap   = no_gaps ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_gaps && $urandom_range(3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk_i) begin : monitor
    pva_out_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        alloc_expect_q = {alloc_expect_q, predict_alloc(in_data_i)};
        accepted++;
        idle_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        if (alloc_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual ch %0d ok %0b stolen %0b",
                   $time, out_data_o.chosen_channel, out_data_o.ok, out_data_o.stolen);
        end else begin
          want = alloc_expect_q.pop_front();
          if (out_data_o.chosen_channel !== want.chosen_channel) begin
            errors++;
            $display("%0t: chosen_channel expected %0d actual %0d",
                     $time, want.chosen_channel, out_data_o.chosen_channel);
          end
          if (out_data_o.ok !== want.ok) begin
            errors++;
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_data_o.ok);
          end
          if (out_data_o.stolen !== want.stolen) begin
            errors++;
            $display("%0t: stolen expected %0b actual %0b",
                     $time, want.stolen, out_data_o.stolen);
          end
        end
      end
    end
  end

  task automatic queue_req(logic [1:0] mode, logic [PrioW-1:0] prio,
                           logic [ChanW-1:0] chan, logic [BusyW-1:0] busy);
    pva_in_t r;
    r.mode         = mode;
    r.priority_req = prio;
    r.channel      = chan;
    r.busy_mask    = busy;
    request_q = {request_q, r};
    issued++;
  endtask

  task automatic wait_drained();
    while (accepted != issued || alloc_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_NUM_CHANNELS:     cfg_num_ch = val;
      CFG_FIRST_3D_CHANNEL: cfg_first_3d = val;
      CFG_HAS_3D:           cfg_has_3d = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned num_ch, int unsigned first_3d, logic has_3d);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_cfg(CFG_NUM_CHANNELS, CfgW'(num_ch));
    write_cfg(CFG_FIRST_3D_CHANNEL, CfgW'(first_3d));
    write_cfg(CFG_HAS_3D, CfgW'(has_3d));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly finds over nearly full masks, plus plays, with clustered priorities,
  // so that stealing and priority ties come up often.
  task automatic queue_random(int unsigned n);
    logic [1:0]       mode;
    logic [PrioW-1:0] prio;
    logic [ChanW-1:0] chan;
    logic [BusyW-1:0] busy;
    int unsigned      count;
    int unsigned      pick;
    no_gaps = ($urandom_range(3) == 0);
    count   = (cfg_num_ch > MAX_CH) ? MAX_CH : cfg_num_ch;
    repeat (n) begin
      case ($urandom_range(7))
        0:       prio = '0;
        1:       prio = '1;
        2, 3, 4: prio = PrioW'($urandom_range(4));
        5:       prio = PrioW'($urandom_range(16'hFFFB, 16'hFFFF));
        default: prio = PrioW'($urandom);
      endcase
      chan = ChanW'($urandom);
      busy = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 30) begin
        mode = MODE_PLAY;
        if (count != 0 && $urandom_range(9) != 0) chan = ChanW'($urandom_range(count - 1));
      end else if (pick < 95) begin
        mode = ($urandom_range(2) == 0) ? MODE_FIND_3D : MODE_FIND_2D;
        case ($urandom_range(5))
          0, 1, 2: busy = '1;
          3:       busy = ~(64'd1 << $urandom_range(63));
          4:       busy = busy & {$urandom, $urandom};
          default: ;
        endcase
      end else begin
        mode = MODE_UNUSED;
      end
      queue_req(mode, prio, chan, busy);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: 64 channels, 3D from channel 0, table all zero
    queue_req(MODE_FIND_2D, 16'h1234, 6'd0, '0);
    queue_req(MODE_FIND_2D, 16'h0000, 6'd0, '1);
    queue_req(MODE_FIND_2D, 16'h0001, 6'd0, '1);
    queue_req(MODE_PLAY, 16'hFFFF, 6'd0, '0);
    queue_req(MODE_PLAY, 16'h0005, 6'd63, '0);
    queue_req(MODE_PLAY, 16'h0005, 6'd62, '0);
    queue_req(MODE_PLAY, 16'h8000, 6'd31, '1);
    queue_req(MODE_FIND_2D, 16'hFFFF, 6'd63, '1);
    queue_req(MODE_FIND_3D, 16'h0000, 6'd0, ~(64'd1 << 63));
    queue_req(MODE_UNUSED, 16'hFFFF, 6'd63, '1);
    queue_req(MODE_FIND_2D, 16'h0006, 6'd0, '1);
    queue_random(60);

    // 3D range in the upper half; busy bits below it do not matter
    apply_setting(64, 32, 1'b1);
    queue_req(MODE_FIND_3D, 16'hFFFF, 6'd0, 64'h0000_0000_FFFF_FFFF);
    queue_req(MODE_FIND_3D, 16'h0006, 6'd0, '1);
    queue_random(70);

    // few channels: play out of range, bits above the count ignored
    apply_setting(8, 4, 1'b1);
    queue_req(MODE_PLAY, 16'h0009, 6'd8, '0);
    queue_req(MODE_PLAY, 16'h0003, 6'd7, '0);
    queue_req(MODE_FIND_3D, 16'h0004, 6'd0, 64'h0000_0000_0000_000F);
    queue_req(MODE_FIND_3D, 16'h0004, 6'd0, 64'h0000_0000_0000_00FF);
    queue_random(70);

    // no channels at all
    apply_setting(0, 0, 1'b1);
    queue_req(MODE_FIND_2D, 16'hFFFF, 6'd0, '0);
    queue_req(MODE_PLAY, 16'h0001, 6'd0, '0);
    queue_random(20);

    // count above the maximum is clamped; 3D start at the count
    apply_setting(127, 64, 1'b1);
    queue_req(MODE_FIND_3D, 16'hFFFF, 6'd0, '0);
    queue_req(MODE_FIND_2D, 16'h0000, 6'd0, ~(64'd1 << 63));
    queue_random(60);

    // no 3D mixer
    apply_setting(64, 63, 1'b0);
    queue_req(MODE_FIND_3D, 16'hFFFF, 6'd0, '0);
    queue_req(MODE_FIND_2D, 16'h0000, 6'd0, '0);
    queue_random(60);

    apply_setting(100, 10, 1'b1);
    queue_random(60);

    repeat (6) begin
      int unsigned num_ch;
      num_ch = ($urandom_range(4) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      apply_setting(num_ch, $urandom_range(num_ch > 64 ? 64 : num_ch), 1'($urandom_range(1)));
      queue_random(60);
    end

    apply_setting(64, 0, 1'b1);
    queue_random(60);

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0 && alloc_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // stop a hung run: too long without any transfer
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pva_pkg.sv
rtl/pva_ctrl.sv
rtl/pva_datapath.sv
rtl/priority_voice_allocator.sv
sim/priority_voice_allocator_tb.sv
